// ===== rtl/tcw_pkg.sv =====
// ============================================================================
// tcw_pkg: shared types and constants of the text console writer
// Command and result beat layouts, character codes and register map.
// ============================================================================
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam logic [7:0] ATTR_RESET = 8'd10;
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_RETURN  = 8'd13;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] TAB_STEP   = 8'd8;

	// Register map: one register, selected by paddr[2].
	localparam int         APB_AW             = 3;
	localparam logic       REG_TEXT_ATTRIBUTE = 1'b0;

	typedef enum logic [1:0] {
		FUNC_PUT   = 2'd0,
		FUNC_SET   = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [7:0]  char_code;
		logic [6:0]  target_column;
		logic [4:0]  target_row;
	} cmd_t;

	typedef struct packed {
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_row;
		logic [15:0] cell_value;
		logic        scrolled;
	} result_t;

endpackage

// ===== rtl/tcw_ram.sv =====
// ============================================================================
// tcw_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/tcw_apb.sv =====
// ============================================================================
// tcw_apb: configuration register file
// Holds the text attribute and answers APB reads of its address with its value, others with zero.
// ============================================================================
module tcw_apb
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [7:0]        attr
);

	logic [7:0] attr_q;

	assign pready = 1'b1;
	assign attr   = attr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_TEXT_ATTRIBUTE) begin
			attr_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_TEXT_ATTRIBUTE) begin
			prdata = {24'd0, attr_q};
		end
	end

endmodule

// ===== rtl/text_console_writer.sv =====
// Put character and set cursor finish straight from idle, a read cell passes through the read state,
// clear screen sweeps every cell, and a put that scrolls copies the rows up, then blanks the bottom row.
// Throughput: one command at a time; busy is high until the command's sweep ends.
// Every cell visit is one access of the single-write, single-read screen RAM.
// After reset a clearing pass over all COLUMNS*ROWS cells blanks the screen; busy is high.
// The result beat is a one-cycle done strobe; the receiver cannot stall it.
// ============================================================================
// text_console_writer: text-mode console engine
// Sequencer that drives one screen RAM for writes, reads, clears and scrolls.
// ============================================================================
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  cmd_t              cmd,
	output logic              done,
	output result_t           result
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);

	localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
	localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
	localparam logic [AW-1:0] SCROLL_END = AW'(CELLS - COLUMNS);
	localparam logic [7:0]    COLS_W     = 8'(COLUMNS);
	localparam logic [5:0]    ROWS_W     = 6'(ROWS);
	localparam logic [6:0]    LAST_COL   = 7'(COLUMNS - 1);
	localparam logic [4:0]    LAST_ROW   = 5'(ROWS - 1);

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_READ   = 6'b000100,
		ST_FILL   = 6'b001000,
		ST_SCROLL = 6'b010000,
		ST_BLANK  = 6'b100000
	} state_t;

	state_t        state_q;
	logic [AW-1:0] cnt_q;
	logic [6:0]    col_q;
	logic [4:0]    row_q;
	result_t       res_q;
	logic          done_q;

	logic [7:0]    attr;
	logic          accept;
	logic [6:0]    tc;
	logic [4:0]    tr;
	logic [AW-1:0] cur_idx;
	logic [AW-1:0] tgt_idx;
	logic          is_nl;
	logic          is_cr;
	logic          is_tab;
	logic          is_ord;
	logic [7:0]    ncol8;
	logic          wrap;
	logic          put_scroll;
	logic [6:0]    put_col;
	logic [4:0]    put_row;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	tcw_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.attr    (attr)
	);

	tcw_ram #(
		.WIDTH (16),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = res_q;

	assign tc = ({1'b0, cmd.target_column} >= COLS_W) ? LAST_COL : cmd.target_column;
	assign tr = ({1'b0, cmd.target_row} >= ROWS_W) ? LAST_ROW : cmd.target_row;

	assign cur_idx = AW'(row_q) * COLS_A + AW'(col_q);
	assign tgt_idx = AW'(tr) * COLS_A + AW'(tc);

	assign is_nl  = (cmd.char_code == CH_NEWLINE);
	assign is_cr  = (cmd.char_code == CH_RETURN);
	assign is_tab = (cmd.char_code == CH_TAB);
	assign is_ord = !is_nl && !is_cr && !is_tab;

	// Tab rounds up to the next multiple of the tab step; nine bits are not needed
	// since the cursor column never exceeds 127.
	assign ncol8 = is_tab ? (({1'b0, col_q} + TAB_STEP) & ~(TAB_STEP - 8'd1))
	                      : ({1'b0, col_q} + 8'd1);
	assign wrap  = is_nl || (!is_cr && ncol8 >= COLS_W);

	always_comb begin
		put_scroll = 1'b0;
		put_col    = col_q;
		put_row    = row_q;
		if (wrap) begin
			put_col = 7'd0;
			if (row_q == LAST_ROW) begin
				put_scroll = 1'b1;
			end else begin
				put_row = row_q + 5'd1;
			end
		end else if (is_cr) begin
			put_col = 7'd0;
		end else begin
			put_col = ncol8[6:0];
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = {attr, CH_SPACE};
		ram_raddr = tgt_idx;
		unique case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = {ATTR_RESET, CH_SPACE};
			end
			ST_IDLE: begin
				if (accept && cmd.func == FUNC_PUT && is_ord) begin
					ram_we    = 1'b1;
					ram_waddr = cur_idx;
					ram_wdata = {attr, cmd.char_code};
				end
			end
			ST_READ: begin
			end
			ST_FILL: begin
				ram_we = 1'b1;
			end
			ST_SCROLL: begin
				// Read one row ahead; the cell read last cycle lands one row up.
				ram_raddr = cnt_q + COLS_A;
				ram_we    = (cnt_q != '0);
				ram_waddr = cnt_q - AW'(1);
				ram_wdata = ram_rdata;
			end
			ST_BLANK: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
			col_q   <= 7'd0;
			row_q   <= 5'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd.func)
							FUNC_PUT: begin
								col_q <= put_col;
								row_q <= put_row;
								if (put_scroll) begin
									cnt_q   <= '0;
									state_q <= ST_SCROLL;
								end else begin
									done_q <= 1'b1;
								end
							end
							FUNC_SET: begin
								col_q  <= tc;
								row_q  <= tr;
								done_q <= 1'b1;
							end
							FUNC_CLEAR: begin
								col_q   <= 7'd0;
								row_q   <= 5'd0;
								cnt_q   <= '0;
								state_q <= ST_FILL;
							end
							FUNC_READ: begin
								state_q <= ST_READ;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_FILL: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_SCROLL: begin
					// The bottom row blank starts at the address the copy ends on.
					if (cnt_q == SCROLL_END) begin
						state_q <= ST_BLANK;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_BLANK: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload; the read data is captured in the read state from the RAM's registered output.
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			res_q.cell_value <= ram_rdata;
		end else if (accept) begin
			res_q.cell_value <= 16'd0;
			res_q.scrolled   <= 1'b0;
			unique case (cmd.func)
				FUNC_PUT: begin
					res_q.cursor_column <= put_col;
					res_q.cursor_row    <= put_row;
					res_q.scrolled      <= put_scroll;
				end
				FUNC_SET: begin
					res_q.cursor_column <= tc;
					res_q.cursor_row    <= tr;
				end
				FUNC_CLEAR: begin
					res_q.cursor_column <= 7'd0;
					res_q.cursor_row    <= 5'd0;
				end
				FUNC_READ: begin
					res_q.cursor_column <= col_q;
					res_q.cursor_row    <= row_q;
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == ST_IDLE)
		else $error("result beat while the sequencer is not idle");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.scrolled) |-> (result.cursor_row == LAST_ROW &&
			result.cursor_column == 7'd0))
		else $error("scroll result with cursor off the bottom line start");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= LAST_COL) && (row_q <= LAST_ROW))
		else $error("cursor outside the screen");

	a_copy_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL && ram_we) |-> ram_waddr != ram_raddr)
		else $error("scroll copy writes the cell it is reading");

	a_scroll_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL && $past(state_q) == ST_IDLE) |->
			(row_q == LAST_ROW && cnt_q == '0))
		else $error("scroll started away from the bottom row");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for the text console writer
// Sends put, set-cursor, clear and read commands in bursts, mirrors the screen
// and cursor in a local model and checks every done beat field by field.
// ============================================================================
module testbench;
	import tcw_pkg::*;

	localparam int COLS  = COLUMNS_DEF;
	localparam int ROWS  = ROWS_DEF;
	localparam int CELLS = COLS * ROWS;

	localparam int RANDOM_PER_PHASE = 470;
	localparam int MAX_GAP          = 12;
	localparam int unsigned CYCLE_LIMIT = 4 * (2000 * (CELLS + MAX_GAP + 8) + 4 * CELLS);

	localparam logic [APB_AW-1:0] ATTR_ADDR = APB_AW'({REG_TEXT_ATTRIBUTE, 2'b00});

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	cmd_t        cmd;
	logic        done;
	result_t     result;

	// Local mirror of the console state.
	logic [15:0] screen_mirror [CELLS];
	int          cur_col;
	int          cur_row;
	logic [7:0]  mirror_attr;

	result_t     report_q [$];
	int          fails;
	int unsigned cycle_count;
	int          burst_left;
	bit          gaps_enabled;
	int          n_puts, n_sets, n_clears, n_reads, n_scrolls, n_attr_writes;

	text_console_writer #(
		.COLUMNS(COLS),
		.ROWS   (ROWS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, report_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++)
			screen_mirror[i] = {mirror_attr, CH_SPACE};
	endfunction

	// Moves to the start of the next row and scrolls when the bottom is passed.
	function automatic bit advance_row();
		cur_col = 0;
		cur_row++;
		if (cur_row < ROWS)
			return 1'b0;
		for (int i = 0; i < CELLS - COLS; i++)
			screen_mirror[i] = screen_mirror[i + COLS];
		for (int i = CELLS - COLS; i < CELLS; i++)
			screen_mirror[i] = {mirror_attr, CH_SPACE};
		cur_row = ROWS - 1;
		return 1'b1;
	endfunction

	function automatic result_t console_update(input cmd_t item);
		result_t r;
		int      tc;
		int      tr;
		r  = '0;
		tc = (item.target_column >= COLS) ? COLS - 1 : int'(item.target_column);
		tr = (item.target_row >= ROWS) ? ROWS - 1 : int'(item.target_row);
		case (item.func)
			FUNC_PUT: begin
				n_puts++;
				if (item.char_code == CH_NEWLINE) begin
					r.scrolled = advance_row();
				end else if (item.char_code == CH_RETURN) begin
					cur_col = 0;
				end else if (item.char_code == CH_TAB) begin
					cur_col = (cur_col + int'(TAB_STEP)) & ~(int'(TAB_STEP) - 1);
					if (cur_col >= COLS)
						r.scrolled = advance_row();
				end else begin
					screen_mirror[cur_row * COLS + cur_col] = {mirror_attr, item.char_code};
					cur_col++;
					if (cur_col >= COLS)
						r.scrolled = advance_row();
				end
			end
			FUNC_SET: begin
				n_sets++;
				cur_col = tc;
				cur_row = tr;
			end
			FUNC_CLEAR: begin
				n_clears++;
				blank_screen();
				cur_col = 0;
				cur_row = 0;
			end
			default: begin
				n_reads++;
				r.cell_value = screen_mirror[tr * COLS + tc];
			end
		endcase
		if (r.scrolled)
			n_scrolls++;
		r.cursor_column = 7'(cur_col);
		r.cursor_row    = 5'(cur_row);
		return r;
	endfunction

	function automatic cmd_t make_cmd(input func_t f, input logic [7:0] ch,
			input logic [6:0] col, input logic [4:0] row);
		cmd_t c;
		c.func          = f;
		c.char_code     = ch;
		c.target_column = col;
		c.target_row    = row;
		return c;
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t        c;
		int unsigned pick;
		c.func          = FUNC_PUT;
		c.char_code     = 8'($urandom_range(0, 255));
		c.target_column = 7'($urandom_range(0, 127));
		c.target_row    = 5'($urandom_range(0, 31));
		pick = $urandom_range(0, 199);
		if (pick < 100) begin
			c.char_code = 8'($urandom_range(32, 126));
		end else if (pick < 110) begin
			// Any byte, control codes included.
		end else if (pick < 124) begin
			c.char_code = CH_NEWLINE;
		end else if (pick < 130) begin
			c.char_code = CH_RETURN;
		end else if (pick < 140) begin
			c.char_code = CH_TAB;
		end else if (pick < 170) begin
			c.func = FUNC_READ;
			// Half of the reads look at the text just written on the cursor row.
			if ($urandom_range(0, 1)) begin
				c.target_row    = 5'(cur_row);
				c.target_column = 7'($urandom_range(0, cur_col));
			end
		end else if (pick < 198) begin
			c.func = FUNC_SET;
			// Bias toward the bottom so that scrolling is reached often.
			if ($urandom_range(0, 1))
				c.target_row = 5'($urandom_range(20, 31));
		end else begin
			c.func = FUNC_CLEAR;
		end
		return c;
	endfunction

	task automatic send_cmd(input cmd_t item);
		int gap;
		if (burst_left == 0) begin
			gap = (gaps_enabled && $urandom_range(0, 2) != 0) ? $urandom_range(1, MAX_GAP) : 0;
			if (gap > 0) begin
				@(negedge clk) start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		cmd   <= item;
		do @(posedge clk); while (busy !== 1'b0);
		report_q.push_back(console_update(item));
	endtask

	// Stops sending and waits until every done beat is in and the block is idle.
	task automatic wait_for_drain();
		@(negedge clk) start <= 1'b0;
		while (report_q.size() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_attribute(input logic [7:0] attr);
		wait_for_drain();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ATTR_ADDR;
		pwdata  <= {24'($urandom()), attr};
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		mirror_attr = attr;
		n_attr_writes++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata[7:0] !== attr) begin
			$error("text_attribute readback: expected %0h, got %0h", attr, prdata[7:0]);
			fails++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done === 1'b1) begin
			if (report_q.size() == 0) begin
				$error("Unexpected done beat: cursor (%0d,%0d) cell %0h",
					result.cursor_column, result.cursor_row, result.cell_value);
				fails++;
			end else begin
				want = report_q.pop_front();
				if (result.cursor_column !== want.cursor_column) begin
					$error("cursor_column: expected %0d, got %0d",
						want.cursor_column, result.cursor_column);
					fails++;
				end
				if (result.cursor_row !== want.cursor_row) begin
					$error("cursor_row: expected %0d, got %0d", want.cursor_row, result.cursor_row);
					fails++;
				end
				if (result.cell_value !== want.cell_value) begin
					$error("cell_value: expected %0h, got %0h", want.cell_value, result.cell_value);
					fails++;
				end
				if (result.scrolled !== want.scrolled) begin
					$error("scrolled: expected %0d, got %0d", want.scrolled, result.scrolled);
					fails++;
				end
			end
		end
	end

	// Plain text, control codes and the extremes of the character byte.
	task automatic test_put_characters();
		send_cmd(make_cmd(FUNC_READ, 8'h00, 7'd5, 5'd5));
		send_cmd(make_cmd(FUNC_PUT, 8'h48, 7'd127, 5'd31));
		send_cmd(make_cmd(FUNC_PUT, 8'h00, 7'd0, 5'd0));
		send_cmd(make_cmd(FUNC_PUT, 8'hFF, 7'd64, 5'd16));
		send_cmd(make_cmd(FUNC_PUT, CH_TAB, 7'd0, 5'd0));
		send_cmd(make_cmd(FUNC_PUT, CH_RETURN, 7'd0, 5'd0));
		send_cmd(make_cmd(FUNC_READ, 8'h00, 7'd0, 5'd0));
		send_cmd(make_cmd(FUNC_PUT, CH_NEWLINE, 7'd0, 5'd0));
	endtask

	// Clamping, wrap at the last column and scrolling past the last row.
	task automatic test_cursor_edges();
		send_cmd(make_cmd(FUNC_SET, 8'h00, 7'd127, 5'd31));
		send_cmd(make_cmd(FUNC_PUT, 8'h5A, 7'd0, 5'd0));
		send_cmd(make_cmd(FUNC_READ, 8'h00, 7'd127, 5'd31));
		send_cmd(make_cmd(FUNC_READ, 8'h00, 7'd79, 5'd23));
		send_cmd(make_cmd(FUNC_SET, 8'h00, 7'd75, 5'd24));
		send_cmd(make_cmd(FUNC_PUT, CH_TAB, 7'd0, 5'd0));
		send_cmd(make_cmd(FUNC_SET, 8'h00, 7'd72, 5'd3));
		send_cmd(make_cmd(FUNC_PUT, CH_TAB, 7'd0, 5'd0));
		send_cmd(make_cmd(FUNC_SET, 8'h00, 7'd10, 5'd24));
		send_cmd(make_cmd(FUNC_PUT, CH_NEWLINE, 7'd0, 5'd0));
	endtask

	// A new attribute applies to later writes and blanks only.
	task automatic test_attribute_change();
		write_attribute(8'h00);
		send_cmd(make_cmd(FUNC_PUT, 8'h61, 7'd0, 5'd0));
		send_cmd(make_cmd(FUNC_READ, 8'h00, 7'd0, 5'd24));
		write_attribute(8'hFF);
		send_cmd(make_cmd(FUNC_PUT, 8'h62, 7'd0, 5'd0));
		send_cmd(make_cmd(FUNC_READ, 8'h00, 7'd0, 5'd24));
		send_cmd(make_cmd(FUNC_CLEAR, 8'h00, 7'd0, 5'd0));
		send_cmd(make_cmd(FUNC_READ, 8'h00, 7'd127, 5'd31));
	endtask

	task automatic test_random_traffic(input logic [7:0] attr, input int count,
			input bit with_gaps);
		write_attribute(attr);
		gaps_enabled = with_gaps;
		burst_left   = 0;
		for (int i = 0; i < count; i++)
			send_cmd(random_cmd());
	endtask

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		start        = 1'b0;
		cmd          = '0;
		fails        = 0;
		cycle_count  = 0;
		burst_left   = 0;
		gaps_enabled = 1'b1;
		cur_col      = 0;
		cur_row      = 0;
		mirror_attr  = ATTR_RESET;
		blank_screen();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_put_characters();
		test_cursor_edges();
		test_attribute_change();
		test_random_traffic(8'($urandom_range(1, 254)), RANDOM_PER_PHASE, 1'b1);
		test_random_traffic(8'h00, RANDOM_PER_PHASE, 1'b0);
		test_random_traffic(8'hFF, RANDOM_PER_PHASE, 1'b1);
		test_random_traffic(ATTR_RESET, RANDOM_PER_PHASE, 1'b1);

		wait_for_drain();
		repeat (32) @(posedge clk);
		$display("Ran %0d puts, %0d cursor sets, %0d clears and %0d cell reads;",
			n_puts, n_sets, n_clears, n_reads);
		$display("the screen scrolled %0d times across %0d attribute settings.",
			n_scrolls, n_attr_writes + 1);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
